// ===== rtl/core/mau_pkg.sv =====
// package for the modular arithmetic unit: widths, opcodes, controller/datapath types
// no dependencies
`default_nettype none
package mau_pkg;
	localparam int OPERAND_BITS_DEF = 64;
	localparam int MODULUS_BITS_DEF = 31;
	localparam logic [30:0] MODULUS_RESET = 31'd1000000007;

	// operation codes
	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_POW = 3'd4;

	// datapath commands
	typedef enum logic [3:0] {
		CMD_NONE    = 4'd0,
		CMD_LOAD    = 4'd1,  // latch operands, start residue of a
		CMD_RED_A   = 4'd2,  // one bit of residue of a
		CMD_RED_B   = 4'd3,  // one bit of residue of b
		CMD_FIXSIGN = 4'd4,  // negate residues of negative operands
		CMD_SETUP   = 4'd5,  // set product operands and exponent
		CMD_MUL     = 4'd6,  // one bit of modular product
		CMD_STEP    = 4'd7,  // write product back and advance exponent
		CMD_DONE    = 4'd8,
		CMD_LAST    = 4'd9   // divide: load a as base for the final product
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic sel_sq;   // product target: 1 square base, 0 update acc
	} ctl_t;

	typedef struct packed {
		logic red_last;  // last bit of reduction
		logic mul_last;  // last bit of multiply
		logic exp_zero;  // exponent exhausted
		logic exp_bit;   // low bit of exponent
		logic need_mul;  // op needs a product chain
		logic final_mul; // divide needs a final a*inv
	} sts_t;
endpackage
`default_nettype wire

// ===== rtl/core/modular_arithmetic_unit_top.sv =====
// top level of the modular arithmetic unit: handshakes, modulus register, output register
// depends on mau_pkg, mau_ctrl, mau_datapath
//
// usage: one word on s_axis (op, operand_a, operand_b) gives one word on m_axis (result).
// the modulus is written on the cfg channel while the unit is idle, a rule for the user
// that the unit does not enforce; reset sets 1000000007. from the accepting edge to
// m_axis_tvalid, both operands are reduced bit-serially and the result is set up;
// that is all for add, subtract and the unused codes. multiply, divide and power add
// per exponent bit one check step and one or two bit-serial modular products, plus
// the S_FIN and S_OUT states at the end; power takes up to a 63-bit exponent, divide
// 31 exponent bits, one load step and one more bit for the product with a.
// one item is in work at a time; s_axis_tready is low while busy or while a result waits.
// the result sits in an output register; when the receiver stalls, the unit holds it
// and accepts the next word only once it is taken. reset clears all control state.
`default_nettype none
module modular_arithmetic_unit_top #(
	parameter int OPERAND_BITS = mau_pkg::OPERAND_BITS_DEF,
	parameter int MODULUS_BITS = mau_pkg::MODULUS_BITS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	// op[2:0], operand_a, operand_b, zero fill
	input  wire [((3+2*OPERAND_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	// result, zero fill
	output logic [((MODULUS_BITS+7)/8)*8-1:0]   m_axis_tdata,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire [MODULUS_BITS-1:0]              cfg_data
);
	import mau_pkg::*;
	localparam int OW = ((MODULUS_BITS+7)/8)*8;
	logic [MODULUS_BITS-1:0] mod_q, res;
	logic busy, done, in_fire;
	ctl_t ctl;
	sts_t sts;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mod_q <= MODULUS_BITS'(MODULUS_RESET);
		else if (cfg_valid) mod_q <= cfg_data;
	end

	assign s_axis_tready = !busy && !m_axis_tvalid;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	mau_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_free(!m_axis_tvalid),
		.sts(sts), .ctl(ctl), .busy(busy), .done(done)
	);
	mau_datapath #(.OPERAND_BITS(OPERAND_BITS), .MODULUS_BITS(MODULUS_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.op_in(s_axis_tdata[2:0]),
		.a_in(s_axis_tdata[3 +: OPERAND_BITS]),
		.b_in(s_axis_tdata[3+OPERAND_BITS +: OPERAND_BITS]),
		.modulus(mod_q), .result(res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
		else if (done) m_axis_tvalid <= 1'b1;
	end
	assign m_axis_tdata = OW'(res);
endmodule
`default_nettype wire

// ===== rtl/core/mau_datapath.sv =====
// datapath: bit-serial reductions and a bit-serial modular multiplier
// depends on mau_pkg
`default_nettype none
module mau_datapath #(
	parameter int OPERAND_BITS = mau_pkg::OPERAND_BITS_DEF,
	parameter int MODULUS_BITS = mau_pkg::MODULUS_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire mau_pkg::ctl_t           ctl,
	output mau_pkg::sts_t                sts,
	input  wire [2:0]                    op_in,
	input  wire [OPERAND_BITS-1:0]       a_in,
	input  wire [OPERAND_BITS-1:0]       b_in,
	input  wire [MODULUS_BITS-1:0]       modulus,
	output logic [MODULUS_BITS-1:0]      result
);
	import mau_pkg::*;
	localparam int CW = $clog2(OPERAND_BITS);
	localparam int MW = MODULUS_BITS;

	logic [2:0] op_q;
	logic [OPERAND_BITS-1:0] a_q, b_q, sh_q, exp_q;
	logic [MW-1:0] m_q, ra_q, rb_q, r_q, acc_q, base_q, x_q, mr_q;
	logic [MW-1:0] y_q;
	logic [CW-1:0] cnt_q;
	logic [MW:0] red_try, mul_d;
	logic [MW+1:0] mul_s;
	logic [MW-1:0] mul_n, one_m, addv, subv, fa, fb, red_n, setup_res;
	logic [MW:0] sum_w;
	logic sa, sb;

	assign sa = a_q[OPERAND_BITS-1];
	assign sb = b_q[OPERAND_BITS-1];
	// magnitude of the operand being reduced, msb first
	assign red_try = {r_q, sh_q[OPERAND_BITS-1]};
	assign red_n = (red_try >= {1'b0, m_q}) ? MW'(red_try - {1'b0, m_q}) : MW'(red_try);
	// multiplier step: r = 2r mod m, then add x if y bit set
	always_comb begin
		mul_d = {mr_q, 1'b0};
		if (mul_d >= {1'b0, m_q}) mul_d = mul_d - {1'b0, m_q};
		mul_s = {1'b0, mul_d} + (y_q[MW-1] ? {2'b0, x_q} : '0);
		if (mul_s >= {2'b0, m_q}) mul_s = mul_s - {2'b0, m_q};
		mul_n = mul_s[MW-1:0];
	end
	assign one_m = (m_q == {{(MW-1){1'b0}}, 1'b1}) ? '0 : {{(MW-1){1'b0}}, 1'b1};
	assign fa = (sa && ra_q != '0) ? m_q - ra_q : ra_q;
	assign fb = (sb && rb_q != '0) ? m_q - rb_q : rb_q;
	always_comb begin
		sum_w = {1'b0, ra_q} + {1'b0, rb_q};
		if (sum_w >= {1'b0, m_q}) sum_w = sum_w - {1'b0, m_q};
		addv = sum_w[MW-1:0];
		subv = (ra_q >= rb_q) ? ra_q - rb_q : ra_q + (m_q - rb_q);
	end

	// result of ops without a product chain, zero for modulus zero
	always_comb begin
		case (op_q)
			OP_ADD:  setup_res = addv;
			OP_SUB:  setup_res = subv;
			default: setup_res = '0;
		endcase
		if (m_q == '0) setup_res = '0;
	end

	assign sts.red_last  = (cnt_q == CW'(OPERAND_BITS-1));
	assign sts.mul_last  = (cnt_q == CW'(MW-1));
	assign sts.exp_zero  = (exp_q == '0);
	assign sts.exp_bit   = exp_q[0];
	assign sts.need_mul  = (op_q == OP_MUL) || (op_q == OP_DIV) || (op_q == OP_POW);
	assign sts.final_mul = (op_q == OP_DIV);

	// control-ish counter and op register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			op_q  <= '0;
		end else begin
			case (ctl.cmd) inside
				CMD_LOAD: begin
					cnt_q <= '0;
					op_q  <= op_in;
				end
				CMD_RED_A, CMD_RED_B, CMD_MUL:
					cnt_q <= (ctl.cmd == CMD_MUL ? sts.mul_last : sts.red_last) ? '0 : cnt_q + 1'b1;
				default: cnt_q <= '0;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (ctl.cmd) inside
			CMD_LOAD: begin
				a_q  <= a_in;
				b_q  <= b_in;
				m_q  <= modulus;
				sh_q <= a_in[OPERAND_BITS-1] ? -a_in : a_in;
				r_q  <= '0;
			end
			CMD_RED_A, CMD_RED_B: begin
				if (sts.red_last) begin
					r_q <= '0;
					if (ctl.cmd == CMD_RED_A) begin
						ra_q <= red_n;
						sh_q <= sb ? -b_q : b_q;
					end else begin
						rb_q <= red_n;
					end
				end else begin
					r_q  <= red_n;
					sh_q <= sh_q << 1;
				end
			end
			CMD_FIXSIGN: begin
				ra_q <= fa;
				rb_q <= fb;
			end
			CMD_SETUP: begin
				acc_q  <= (op_q == OP_MUL) ? ra_q : one_m;
				mr_q   <= '0;
				result <= setup_res;
				case (op_q)
					OP_MUL: begin
						base_q <= rb_q;
						exp_q  <= OPERAND_BITS'(1);
					end
					OP_DIV: begin
						base_q <= rb_q;
						exp_q  <= (m_q >= MW'(3)) ? OPERAND_BITS'(m_q - MW'(2)) : '0;
					end
					OP_POW: begin
						base_q <= ra_q;
						exp_q  <= sb ? '0 : b_q;
					end
					default: ;
				endcase
			end
			CMD_MUL: begin
				if (cnt_q == '0) begin
					// first bit: r = x if top bit of y set
					x_q  <= ctl.sel_sq ? base_q : acc_q;
					y_q  <= base_q << 1;
					mr_q <= base_q[MW-1] ? (ctl.sel_sq ? base_q : acc_q) : '0;
				end else begin
					mr_q <= mul_n;
					y_q  <= y_q << 1;
				end
			end
			CMD_STEP: begin
				if (ctl.sel_sq) begin
					base_q <= mr_q;
					exp_q  <= exp_q >> 1;
				end else begin
					acc_q <= mr_q;
				end
			end
			// divide: acc holds the inverse, one more bit multiplies it by a
			CMD_LAST: begin
				base_q <= ra_q;
				exp_q  <= OPERAND_BITS'(1);
			end
			CMD_DONE: begin
				if (sts.need_mul) result <= (m_q == '0) ? '0 : acc_q;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/core/mau_ctrl.sv =====
// controller state machine sequencing reductions and square-and-multiply
// depends on mau_pkg
`default_nettype none
module mau_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_fire,
	input  wire                 out_free,
	input  wire mau_pkg::sts_t  sts,
	output mau_pkg::ctl_t       ctl,
	output logic                busy,
	output logic                done
);
	import mau_pkg::*;
	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_REDA  = 10'b0000000010,
		S_REDB  = 10'b0000000100,
		S_FIX   = 10'b0000001000,
		S_SET   = 10'b0000010000,
		S_CHK   = 10'b0000100000,
		S_MUL   = 10'b0001000000,
		S_STEP  = 10'b0010000000,
		S_FIN   = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;
	state_t state_q;
	logic sq_q, fin_q;

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_OUT) && out_free;

	always_comb begin
		ctl.sel_sq = sq_q;
		unique case (state_q)
			S_IDLE:  ctl.cmd = in_fire ? CMD_LOAD : CMD_NONE;
			S_REDA:  ctl.cmd = CMD_RED_A;
			S_REDB:  ctl.cmd = CMD_RED_B;
			S_FIX:   ctl.cmd = CMD_FIXSIGN;
			S_SET:   ctl.cmd = CMD_SETUP;
			S_CHK:   ctl.cmd = (sts.exp_zero && sts.final_mul && !fin_q) ? CMD_LAST : CMD_NONE;
			S_MUL:   ctl.cmd = CMD_MUL;
			S_STEP:  ctl.cmd = CMD_STEP;
			S_FIN:   ctl.cmd = CMD_NONE;
			S_OUT:   ctl.cmd = out_free ? CMD_DONE : CMD_NONE;
			default: ctl.cmd = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sq_q    <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_fire) begin
					state_q <= S_REDA;
					fin_q   <= 1'b0;
				end
				S_REDA: if (sts.red_last) state_q <= S_REDB;
				S_REDB: if (sts.red_last) state_q <= S_FIX;
				S_FIX:  state_q <= S_SET;
				S_SET:  state_q <= sts.need_mul ? S_CHK : S_OUT;
				// exponent loop: multiply acc if bit set, then square
				S_CHK: begin
					if (sts.exp_zero) begin
						// divide takes one more pass for the product with a
						if (sts.final_mul && !fin_q) fin_q <= 1'b1;
						else state_q <= S_FIN;
					end else begin
						sq_q    <= !sts.exp_bit;
						state_q <= S_MUL;
					end
				end
				S_MUL:  if (sts.mul_last) state_q <= S_STEP;
				S_STEP: begin
					if (sq_q) state_q <= S_CHK;
					else begin
						sq_q    <= 1'b1;
						state_q <= S_MUL;
					end
				end
				S_FIN: state_q <= S_OUT;
				S_OUT: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
